// ===== sv/smc_pkg.sv =====
`timescale 1ns / 1ps

package smc_pkg;

  localparam int MAX_DISP   = 32;
  localparam int MAX_WIDTH  = 2048;
  localparam int HIST_DEPTH = MAX_DISP + 2;
  localparam int NCH        = 3;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int DISP_W     = 5;
  localparam int ND_W       = 6;
  localparam int COST_W     = 16;
  localparam int SUM_W      = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [SUM_W-1:0] PIX_MAX    = SUM_W'(255);
  localparam logic [SUM_W-1:0] PIX_MAX_SQ = SUM_W'(255 * 255);

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DISP       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLORS     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_USE_BIRCHFIELD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SQUARED_DIFFS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRUNC_DIFF     = 3'd4;

  // channel 0 (red) in the low byte
  typedef logic [NCH-1:0][PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [DISP_W-1:0] disp;
    logic              last;
    logic              invalid;
  } meta_t;

  // pixel under test and its neighbors in both images, edges already resolved
  typedef struct packed {
    pixel_t c1;
    pixel_t l1;
    pixel_t r1;
    pixel_t c2;
    pixel_t l2;
    pixel_t r2;
  } taps_t;

  typedef struct packed {
    logic              use_bt;
    logic              sq;
    logic [1:0]        nc;
    logic [COST_W-1:0] lim;
    logic [COST_W-1:0] inval;
  } cost_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_LOADB
  } state_t;

endpackage

// ===== sv/smc_cell.sv =====
`timescale 1ns / 1ps

module smc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  logic            load,
  input  logic            step,
  input  smc_pkg::pixel_t prev_pix,
  input  smc_pkg::pixel_t next_scan,
  output smc_pkg::pixel_t hist_o,
  output smc_pkg::pixel_t scan_o
);
  import smc_pkg::*;

  pixel_t hist_r;
  pixel_t scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (shift) begin
      hist_r <= prev_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scan_r <= prev_pix;
    end else if (step) begin
      scan_r <= next_scan;
    end
  end

  assign hist_o = hist_r;
  assign scan_o = scan_r;

endmodule

// ===== sv/smc_cost.sv =====
`timescale 1ns / 1ps

module smc_cost (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               issue,
  input  smc_pkg::meta_t     meta_i,
  input  smc_pkg::taps_t     taps_i,
  input  smc_pkg::cost_cfg_t cfg_i,
  output logic               en_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // column[10:0], disparity[15:11], cost[31:16]
  output logic               out_tlast
);
  import smc_pkg::*;

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W:1];
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] dissim(
    input logic             bt,
    input logic [PIX_W-1:0] c1, input logic [PIX_W-1:0] l1n, input logic [PIX_W-1:0] r1n,
    input logic [PIX_W-1:0] c2, input logic [PIX_W-1:0] l2n, input logic [PIX_W-1:0] r2n);
    logic [PIX_W-1:0] mn1, mx1, mn2, mx2, d1, d2;
    mn1 = min3(c1, avg2(c1, l1n), avg2(c1, r1n));
    mx1 = max3(c1, avg2(c1, l1n), avg2(c1, r1n));
    mn2 = min3(c2, avg2(c2, l2n), avg2(c2, r2n));
    mx2 = max3(c2, avg2(c2, l2n), avg2(c2, r2n));
    d1 = (c1 > mx2) ? c1 - mx2 : ((mn2 > c1) ? mn2 - c1 : '0);
    d2 = (c2 > mx1) ? c2 - mx1 : ((mn1 > c2) ? mn1 - c2 : '0);
    if (!bt) begin
      return (c1 > c2) ? c1 - c2 : c2 - c1;
    end
    return (d1 < d2) ? d1 : d2;
  endfunction

  logic                          en;
  logic                          v1_r, v2_r, out_valid_r;
  meta_t                         meta1_r, meta2_r;
  logic [NCH-1:0][PIX_W-1:0]     diff_nxt, diff1_r;
  logic [NCH-1:0][2*PIX_W-1:0]   term_nxt, term2_r;
  logic [SUM_W-1:0]              sum;
  logic [COST_W-1:0]             cost_nxt;
  logic [31:0]                   data_r;
  logic                          last_r;

  assign en   = !out_valid_r || out_tready;
  assign en_o = en;

  always_comb begin
    for (int b = 0; b < NCH; b++) begin
      if (2'(b) < cfg_i.nc) begin
        diff_nxt[b] = dissim(cfg_i.use_bt, taps_i.c1[b], taps_i.l1[b], taps_i.r1[b],
                             taps_i.c2[b], taps_i.l2[b], taps_i.r2[b]);
      end else begin
        diff_nxt[b] = '0;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < NCH; b++) begin
      term_nxt[b] = cfg_i.sq ? (2*PIX_W)'(diff1_r[b]) * (2*PIX_W)'(diff1_r[b])
                             : (2*PIX_W)'(diff1_r[b]);
    end
  end

  always_comb begin
    sum = '0;
    for (int b = 0; b < NCH; b++) begin
      sum = sum + SUM_W'(term2_r[b]);
    end
    if (meta2_r.invalid) begin
      cost_nxt = cfg_i.inval;
    end else if (sum < SUM_W'(cfg_i.lim)) begin
      cost_nxt = sum[COST_W-1:0];
    end else begin
      cost_nxt = cfg_i.lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r <= meta_i;
      diff1_r <= diff_nxt;
      meta2_r <= meta1_r;
      term2_r <= term_nxt;
      data_r  <= {cost_nxt, meta2_r.disp, meta2_r.col};
      last_r  <= meta2_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ===== sv/stereo_matching_cost.sv =====
`timescale 1ns / 1ps
// Streaming stereo matching cost (AD or Birchfield-Tomasi, optionally squared).
// Input: one left/right pixel pair per transaction on in_*, in_tlast marks
// the last pixel of a scanline. Output: one cost per (left pixel, disparity)
// on out_*, disparities 0..N-1 in order (N = num_disp clamped to 1..32);
// out_tlast flags the final result caused by one input transaction.
// A pixel's costs leave when the next pixel is taken; at line end the costs
// of the last pixel follow directly. The first pixel of a line that is not
// also its last causes no result.
// Costs are issued one per cycle while the output is not stalled, from a
// chain of right-pixel cells that shifts one disparity step per issue.
// A pixel issues one cost per disparity; at line end ST_LOADB reloads the
// chain for the last pixel's costs. A first pixel that is not a line end
// issues none. Issued costs pass the difference, term and output registers
// before out_tvalid rises. A new input is taken only when the previous one
// has been fully issued. A stalled receiver freezes the 3-stage cost pipeline
// and the issue chain; nothing is dropped. Configuration (cfg_*) is to be
// written by the user only while idle; the block does not enforce it.
// Reset (rst_n, synchronous) clears the line position, the pixel history
// and restores the register defaults 32, 3, 1, 0, 255.
module stereo_matching_cost (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // left_red, left_green, left_blue, right_red, right_green, right_blue
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // column[10:0], disparity[15:11], cost[31:16]
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import smc_pkg::*;

  // configuration
  logic [ND_W-1:0]   num_disp_r;
  logic [1:0]        num_colors_r;
  logic              use_bt_r;
  logic              sq_r;
  logic [PIX_W-1:0]  trunc_r;
  logic [ND_W-1:0]   nd_r;
  cost_cfg_t         ccfg_r;
  logic [1:0]        nc_c;
  logic [COST_W-1:0] lim_c;
  logic [SUM_W-1:0]  worst_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_disp_r   <= ND_W'(MAX_DISP);
      num_colors_r <= 2'd3;
      use_bt_r     <= 1'b1;
      sq_r         <= 1'b0;
      trunc_r      <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_DISP:       num_disp_r   <= cfg_wdata[ND_W-1:0];
        CFG_NUM_COLORS:     num_colors_r <= cfg_wdata[1:0];
        CFG_USE_BIRCHFIELD: use_bt_r     <= cfg_wdata[0];
        CFG_SQUARED_DIFFS:  sq_r         <= cfg_wdata[0];
        CFG_TRUNC_DIFF:     trunc_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    nc_c    = (num_colors_r == 2'd0) ? 2'd1 : num_colors_r;
    lim_c   = sq_r ? COST_W'(trunc_r) * COST_W'(trunc_r) : COST_W'(nc_c) * COST_W'(trunc_r);
    worst_c = SUM_W'(nc_c) * (sq_r ? PIX_MAX_SQ : PIX_MAX);
  end

  always_ff @(posedge clk) begin
    if (num_disp_r == '0) begin
      nd_r <= ND_W'(1);
    end else if (num_disp_r > ND_W'(MAX_DISP)) begin
      nd_r <= ND_W'(MAX_DISP);
    end else begin
      nd_r <= num_disp_r;
    end
    ccfg_r.use_bt <= use_bt_r;
    ccfg_r.sq     <= sq_r;
    ccfg_r.nc     <= nc_c;
    ccfg_r.lim    <= lim_c;
    ccfg_r.inval  <= (worst_c < SUM_W'(lim_c)) ? worst_c[COST_W-1:0] : lim_c;
  end

  // control
  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   x_r, x_nxt;
  logic [DISP_W-1:0]  d_r, d_nxt;
  logic               pend_r, pend_nxt;
  logic               lastcol_r, lastcol_nxt;
  logic               accept, line_end, last_item, issue, load, en;
  pixel_t             lw_r [3];
  pixel_t             left_in, right_in;

  assign left_in   = in_tdata[23:0];
  assign right_in  = in_tdata[47:24];
  assign accept    = in_tvalid && in_tready;
  assign line_end  = in_tlast || (col_r >= COL_W'(MAX_WIDTH - 1));
  assign last_item = (d_r == DISP_W'(nd_r - ND_W'(1)));

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    x_nxt       = x_r;
    d_nxt       = d_r;
    pend_nxt    = pend_r;
    lastcol_nxt = lastcol_r;
    in_tready   = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          load    = 1'b1;
          col_nxt = line_end ? '0 : col_r + COL_W'(1);
          d_nxt   = '0;
          if (col_r != '0) begin
            state_nxt   = ST_EMIT;
            x_nxt       = col_r - COL_W'(1);
            lastcol_nxt = 1'b0;
            pend_nxt    = line_end;
          end else if (line_end) begin
            state_nxt = ST_LOADB;
            x_nxt     = col_r;
            pend_nxt  = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (en) begin
          issue = 1'b1;
          if (last_item) begin
            d_nxt = '0;
            if (pend_r) begin
              state_nxt = ST_LOADB;
              x_nxt     = x_r + COL_W'(1);
              pend_nxt  = 1'b0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            d_nxt = d_r + DISP_W'(1);
          end
        end
      end
      ST_LOADB: begin
        load        = 1'b1;
        lastcol_nxt = 1'b1;
        d_nxt       = '0;
        state_nxt   = ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      col_r     <= '0;
      x_r       <= '0;
      d_r       <= '0;
      pend_r    <= 1'b0;
      lastcol_r <= 1'b0;
      lw_r[0]   <= '0;
      lw_r[1]   <= '0;
      lw_r[2]   <= '0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      x_r       <= x_nxt;
      d_r       <= d_nxt;
      pend_r    <= pend_nxt;
      lastcol_r <= lastcol_nxt;
      if (accept) begin
        lw_r[0] <= left_in;
        lw_r[1] <= lw_r[0];
        lw_r[2] <= lw_r[1];
      end
    end
  end

  // right history / scan chain
  pixel_t hist_w [HIST_DEPTH];
  pixel_t scan_w [HIST_DEPTH];

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    pixel_t prev_pix, next_scan;
    if (i == 0) begin : g_head
      assign prev_pix = right_in;
    end else begin : g_body
      assign prev_pix = hist_w[i-1];
    end
    if (i == HIST_DEPTH - 1) begin : g_tail
      assign next_scan = scan_w[i];
    end else begin : g_mid
      assign next_scan = scan_w[i+1];
    end
    smc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (accept),
      .load      (load),
      .step      (issue),
      .prev_pix  (prev_pix),
      .next_scan (next_scan),
      .hist_o    (hist_w[i]),
      .scan_o    (scan_w[i])
    );
  end

  // taps for the current disparity
  taps_t taps;
  meta_t meta;
  logic  d_eq_x;

  assign d_eq_x = ({{(COL_W-DISP_W){1'b0}}, d_r} == x_r);

  always_comb begin
    taps.c1 = lastcol_r ? lw_r[0] : lw_r[1];
    taps.l1 = (x_r == '0) ? taps.c1 : (lastcol_r ? lw_r[1] : lw_r[2]);
    taps.r1 = lastcol_r ? taps.c1 : lw_r[0];
    taps.c2 = scan_w[1];
    taps.l2 = d_eq_x ? taps.c2 : scan_w[2];
    taps.r2 = (lastcol_r && d_r == '0) ? taps.c2 : scan_w[0];
    meta.col     = x_r;
    meta.disp    = d_r;
    meta.last    = last_item && !pend_r;
    meta.invalid = ({{(COL_W-DISP_W){1'b0}}, d_r} > x_r);
  end

  smc_cost u_cost (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .meta_i     (meta),
    .taps_i     (taps),
    .cfg_i      (ccfg_r),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
